### design/dispense_session_controller_macros.svh
// Assertion macros for the dispense session controller.
// Depends on nothing; included by the top level.
`ifndef DISPENSE_SESSION_CONTROLLER_MACROS_SVH
`define DISPENSE_SESSION_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
`define DSC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define DSC_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DSC_ASSERT(label, clk, rst_n, prop)
`define DSC_ASSERT_NR(label, clk, prop)
`endif
`endif

### design/dsc_pkg.sv
// Package for the dispense session controller: phase, event and command codes.
// Depends on nothing.
`timescale 1ns / 1ps
package dsc_pkg;
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_WAIT     = 3'd1;
  localparam logic [2:0] PH_READY    = 3'd2;
  localparam logic [2:0] PH_RUN      = 3'd3;
  localparam logic [2:0] PH_PAUSE    = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;
  localparam logic [2:0] PH_WAITIDLE = 3'd6;

  localparam logic [2:0] FN_TICK     = 3'd0;
  localparam logic [2:0] FN_ORDER    = 3'd1;
  localparam logic [2:0] FN_START    = 3'd2;
  localparam logic [2:0] FN_STOP     = 3'd3;
  localparam logic [2:0] FN_CONTINUE = 3'd4;
  localparam logic [2:0] FN_FINISH   = 3'd5;
  localparam logic [2:0] FN_FAULT    = 3'd6;
  localparam logic [2:0] FN_SRESET   = 3'd7;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_POSTPAY = 2'd1;
  localparam logic [1:0] EV_IDLE    = 2'd2;

  localparam logic [1:0] AB_NONE  = 2'd0;
  localparam logic [1:0] AB_ABORT = 2'd1;
  localparam logic [1:0] AB_PAUSE = 2'd2;

  localparam logic [2:0] CFG_POLL     = 3'd0;
  localparam logic [2:0] CFG_DEBOUNCE = 3'd1;
  localparam logic [2:0] CFG_PAUSE    = 3'd2;
  localparam logic [2:0] CFG_FINISH   = 3'd3;
  localparam logic [2:0] CFG_POSTPAY  = 3'd4;

  function automatic logic reached(input logic [31:0] t, input logic [31:0] dl);
    logic [31:0] d;
    d = t - dl;
    return ~d[31];
  endfunction
endpackage

### design/dispense_session_controller.sv
// Dispense session controller: one event per item, one result per item.
// An accepted item's result is registered in the output register, or in the skid spare while the output is held.
// Throughput: one item per cycle while the skid spare is empty; a held result is parted by a skid stage.
// Reset (rst_n, synchronous, active low) puts the phase to idle, clears all
// session state and loads the register defaults. No clearing pass.
// Depends on dsc_pkg and dispense_session_controller_macros.svh.
`timescale 1ns / 1ps
`include "dispense_session_controller_macros.svh"
module dispense_session_controller
  import dsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[2:0]
  input  logic [2:0]  in_tuser,
  // now_ms[31:0], order_tag[63:32], order_len_ms[95:64],
  // container_present[96], pump_busy[97], wake_ready[98], standby_on[99],
  // tray_full[100], tank_empty[101], start_ok[102], done_seen[103]
  input  logic [103:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // accepted[0], event_code[2:1], phase_now[5:3], start_request[6],
  // start_length_ms[38:7], abort_cmd[40:39], standby_enable[41],
  // dispensed_total_ms[73:42], continue_visible[74]; zero fill
  output logic [79:0] out_tdata
);
  // configuration
  logic [15:0] poll_r;
  logic [3:0]  deb_r;
  logic [31:0] pto_r, fho_r, ppo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r <= 16'd100; deb_r <= 4'd3; pto_r <= 32'd60000;
      fho_r <= 32'd3000; ppo_r <= 32'd120000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLL:     poll_r <= cfg_data[15:0];
        CFG_DEBOUNCE: deb_r <= cfg_data[3:0];
        CFG_PAUSE:    pto_r <= cfg_data;
        CFG_FINISH:   fho_r <= cfg_data;
        CFG_POSTPAY:  ppo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // skid stage: main output register plus one spare
  logic        ov_r, sv_r;
  logic [74:0] od_r, sd_r;
  assign in_tready  = ~sv_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, od_r};
  wire take = in_tvalid & in_tready;

  // session state
  logic [2:0]  ph_r, ph_nxt;
  logic [31:0] fdl_r, fdl_nxt, lpt_r, lpt_nxt, con_r, con_nxt, acc_r, acc_nxt;
  logic [31:0] seg_r, seg_nxt, pdl_r, pdl_nxt, pend_r, pend_nxt, ppd_r, ppd_nxt;
  logic [31:0] lord_r, lord_nxt;
  logic [3:0]  stk_r, stk_nxt;
  logic        pv_r, pv_nxt, pa_r, pa_nxt, rp_r, rp_nxt;

  // fields
  logic [2:0]  fn;
  logic [31:0] t, tag, dur;
  logic        pres, busy, wake, stby, tray, tank, ok, done;
  assign fn = in_tuser;        assign t = in_tdata[31:0];
  assign tag = in_tdata[63:32]; assign dur = in_tdata[95:64];
  assign pres = in_tdata[96];  assign busy = in_tdata[97];
  assign wake = in_tdata[98];  assign stby = in_tdata[99];
  assign tray = in_tdata[100]; assign tank = in_tdata[101];
  assign ok = in_tdata[102];   assign done = in_tdata[103];

  // values seen from the state at entry
  logic [31:0] run_len, tot0, left0, pd;
  logic        left0_nz, poll_due, sense_hit;
  logic [3:0]  stk_poll;
  always_comb begin
    run_len  = t - seg_r;
    tot0     = (ph_r == PH_RUN) ? acc_r + run_len : acc_r;
    left0    = (con_r == 32'd0 || tot0 >= con_r) ? 32'd0 : con_r - tot0;
    left0_nz = left0 != 32'd0;
    pd       = t - lpt_r;
    poll_due = !(pv_r && (pd[31] || pd < {16'd0, poll_r}));
    // sense with wanted = absent for every caller except the wait phase
    if (pres == (ph_r == PH_WAIT))
      stk_poll = (stk_r < deb_r) ? stk_r + 4'd1 : stk_r;
    else
      stk_poll = 4'd0;
    sense_hit = poll_due && (stk_poll >= deb_r);
  end

  logic        o_acc, o_start, o_stb;
  logic [1:0]  o_ev, o_ab;
  logic [31:0] o_len, tot_n;
  logic        vis;

  always_comb begin
    ph_nxt = ph_r; fdl_nxt = fdl_r; lpt_nxt = lpt_r; con_nxt = con_r;
    acc_nxt = acc_r; seg_nxt = seg_r; pdl_nxt = pdl_r; pend_nxt = pend_r;
    ppd_nxt = ppd_r; lord_nxt = lord_r; stk_nxt = stk_r; pv_nxt = pv_r;
    pa_nxt = pa_r; rp_nxt = rp_r;
    o_acc = 1'b0; o_ev = EV_NONE; o_start = 1'b0; o_len = 32'd0;
    o_ab = AB_NONE; o_stb = 1'b0;
    case (fn)
      FN_TICK: begin
        if (ph_r == PH_WAIT || ph_r == PH_READY) begin
          if (reached(t, ppd_r)) begin
            ph_nxt = PH_IDLE; fdl_nxt = '0; lpt_nxt = '0; pv_nxt = 1'b0;
            con_nxt = '0; acc_nxt = '0; seg_nxt = '0; pdl_nxt = '0;
            pa_nxt = 1'b0; pend_nxt = '0; ppd_nxt = '0; stk_nxt = '0;
            rp_nxt = 1'b0; o_ev = EV_POSTPAY;
          end else if (poll_due) begin
            lpt_nxt = t; pv_nxt = 1'b1; stk_nxt = stk_poll;
            if (sense_hit) begin
              ph_nxt = (ph_r == PH_WAIT) ? PH_READY : PH_WAIT;
              stk_nxt = '0; pv_nxt = 1'b0;
            end
          end
        end else if (ph_r == PH_RUN) begin
          if (poll_due) begin
            lpt_nxt = t; pv_nxt = 1'b1; stk_nxt = stk_poll;
          end
          if (sense_hit) begin
            acc_nxt = tot0; seg_nxt = '0; o_ab = AB_ABORT;
            pdl_nxt = '0; pa_nxt = 1'b0; rp_nxt = 1'b0;
            ph_nxt = PH_DONE; fdl_nxt = t + fho_r; con_nxt = '0;
          end else begin
            o_stb = !busy && wake;
            if (!left0_nz) begin
              acc_nxt = tot0; seg_nxt = '0;
              ph_nxt = PH_DONE; fdl_nxt = t + fho_r; con_nxt = '0;
            end
          end
        end else if (ph_r == PH_PAUSE) begin
          if (pa_r && reached(t, pdl_r)) begin
            pdl_nxt = '0; pa_nxt = 1'b0; rp_nxt = 1'b0;
            ph_nxt = PH_DONE; fdl_nxt = t + fho_r; con_nxt = '0;
          end else begin
            if (poll_due) begin
              lpt_nxt = t; pv_nxt = 1'b1; stk_nxt = stk_poll;
            end
            if (sense_hit) begin
              pdl_nxt = '0; pa_nxt = 1'b0; rp_nxt = 1'b0;
              ph_nxt = PH_DONE; fdl_nxt = t + fho_r; con_nxt = '0;
            end else begin
              o_stb = !busy && wake;
              if (rp_r && !busy && stby && pres && left0_nz) begin
                o_start = 1'b1; o_len = left0;
                if (ok) begin
                  seg_nxt = t; rp_nxt = 1'b0; ph_nxt = PH_RUN;
                  stk_nxt = '0; pv_nxt = 1'b0;
                end
              end
            end
          end
        end else if (ph_r == PH_DONE) begin
          if (reached(t, fdl_r)) ph_nxt = PH_WAITIDLE;
        end else if (ph_r == PH_WAITIDLE) begin
          if (done || !busy) begin
            ph_nxt = PH_IDLE; fdl_nxt = '0; lpt_nxt = '0; pv_nxt = 1'b0;
            con_nxt = '0; acc_nxt = '0; seg_nxt = '0; pdl_nxt = '0;
            pa_nxt = 1'b0; pend_nxt = '0; ppd_nxt = '0; stk_nxt = '0;
            rp_nxt = 1'b0; o_stb = 1'b1; o_ev = EV_IDLE;
          end
        end
      end
      FN_ORDER: begin
        if (tag != 32'd0 && ph_r == PH_IDLE && tag != lord_r && wake) begin
          o_stb = !stby; lord_nxt = tag; pend_nxt = dur; con_nxt = '0;
          acc_nxt = '0; seg_nxt = '0; ppd_nxt = t + ppo_r;
          ph_nxt = pres ? PH_READY : PH_WAIT; stk_nxt = '0; pv_nxt = 1'b0;
          o_acc = 1'b1;
        end
      end
      FN_START: begin
        if (ph_r == PH_READY && !tray && !tank) begin
          if (!pres) begin
            ph_nxt = PH_WAIT; stk_nxt = '0; pv_nxt = 1'b0;
          end else begin
            o_start = 1'b1; o_len = pend_r;
            if (ok) begin
              con_nxt = pend_r; acc_nxt = '0; seg_nxt = t; pdl_nxt = '0;
              pa_nxt = 1'b0; ppd_nxt = '0; rp_nxt = 1'b0; ph_nxt = PH_RUN;
              fdl_nxt = '0; stk_nxt = '0; pv_nxt = 1'b0; o_acc = 1'b1;
            end
          end
        end
      end
      FN_STOP: begin
        if (ph_r == PH_RUN) begin
          acc_nxt = tot0; seg_nxt = '0; o_ab = AB_PAUSE; ph_nxt = PH_PAUSE;
          pdl_nxt = t + pto_r; pa_nxt = 1'b1; rp_nxt = 1'b0;
          stk_nxt = '0; pv_nxt = 1'b0; o_acc = 1'b1;
        end
      end
      FN_CONTINUE: begin
        if (ph_r == PH_PAUSE && !tray && !tank && pres) begin
          if (!left0_nz) begin
            pdl_nxt = '0; pa_nxt = 1'b0; rp_nxt = 1'b0;
            ph_nxt = PH_DONE; fdl_nxt = t + fho_r; con_nxt = '0; o_acc = 1'b1;
          end else begin
            pdl_nxt = '0; pa_nxt = 1'b0;
            if (busy) begin
              rp_nxt = 1'b1; o_acc = 1'b1;
            end else begin
              o_stb = wake; o_start = 1'b1; o_len = left0;
              if (ok) begin
                seg_nxt = t; rp_nxt = 1'b0; ph_nxt = PH_RUN;
                stk_nxt = '0; pv_nxt = 1'b0; o_acc = 1'b1;
              end
            end
          end
        end
      end
      FN_FINISH: begin
        if (ph_r == PH_PAUSE) begin
          pdl_nxt = '0; pa_nxt = 1'b0; rp_nxt = 1'b0;
          ph_nxt = PH_DONE; fdl_nxt = t + fho_r; con_nxt = '0; o_acc = 1'b1;
        end
      end
      FN_FAULT: begin
        if (ph_r == PH_RUN) o_ab = AB_ABORT;
        ph_nxt = PH_IDLE; fdl_nxt = '0; lpt_nxt = '0; pv_nxt = 1'b0;
        con_nxt = '0; acc_nxt = '0; seg_nxt = '0; pdl_nxt = '0;
        pa_nxt = 1'b0; pend_nxt = '0; ppd_nxt = '0; stk_nxt = '0;
        rp_nxt = 1'b0; o_acc = 1'b1;
      end
      default: begin
        lord_nxt = '0; o_acc = 1'b1;
      end
    endcase
  end

  // outputs after the step; contract remaining only matters while paused
  logic [31:0] left_n;
  always_comb begin
    tot_n  = (ph_nxt == PH_RUN) ? acc_nxt + (t - seg_nxt) : acc_nxt;
    left_n = (con_nxt == 32'd0 || acc_nxt >= con_nxt) ? 32'd0 : con_nxt - acc_nxt;
    vis = ph_nxt == PH_PAUSE && !rp_nxt && !busy && stby && pres
          && left_n != 32'd0;
  end

  wire [74:0] res = {vis, tot_n, o_stb, o_ab, o_len, o_start, ph_nxt, o_ev, o_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; fdl_r <= '0; lpt_r <= '0; con_r <= '0; acc_r <= '0;
      seg_r <= '0; pdl_r <= '0; pend_r <= '0; ppd_r <= '0; lord_r <= '0;
      stk_r <= '0; pv_r <= 1'b0; pa_r <= 1'b0; rp_r <= 1'b0;
    end else if (take) begin
      ph_r <= ph_nxt; fdl_r <= fdl_nxt; lpt_r <= lpt_nxt; con_r <= con_nxt;
      acc_r <= acc_nxt; seg_r <= seg_nxt; pdl_r <= pdl_nxt; pend_r <= pend_nxt;
      ppd_r <= ppd_nxt; lord_r <= lord_nxt; stk_r <= stk_nxt; pv_r <= pv_nxt;
      pa_r <= pa_nxt; rp_r <= rp_nxt;
    end
  end

  // output register and skid spare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; sv_r <= 1'b0;
    end else begin
      if (!ov_r || out_tready) begin
        ov_r <= sv_r | take;
        sv_r <= 1'b0;
      end else if (take) begin
        sv_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || out_tready) begin
      od_r <= sv_r ? sd_r : res;
    end
    if (take && ov_r && !out_tready) sd_r <= res;
    else if (take && sv_r && (!ov_r || out_tready)) sd_r <= res;
  end

  `DSC_ASSERT(a_skid_full_holds, clk, rst_n, sv_r |-> ov_r)
  `DSC_ASSERT(a_no_take_when_full, clk, rst_n, sv_r |-> !take)
  `DSC_ASSERT(a_phase_range, clk, rst_n, ph_r != 3'd7)
  `DSC_ASSERT(a_streak_bound, clk, rst_n, take |=> (stk_r <= 4'd15))
endmodule

### dv/tb_dispense_session_controller.sv
`timescale 1ns / 1ps
// Testbench for the dispense session controller: drives event items through
// the stream port, predicts each result in a local session model and compares.
// Depends on dsc_pkg and the dispense_session_controller RTL.
module tb_dispense_session_controller;
  import dsc_pkg::*;

  typedef struct packed {
    logic        done_seen;
    logic        start_ok;
    logic        tank_empty;
    logic        tray_full;
    logic        standby_on;
    logic        wake_ready;
    logic        pump_busy;
    logic        container_present;
    logic [31:0] order_len_ms;
    logic [31:0] order_tag;
    logic [31:0] now_ms;
    logic [2:0]  func;
  } event_t;

  typedef struct packed {
    logic        continue_visible;
    logic [31:0] dispensed_total_ms;
    logic        standby_enable;
    logic [1:0]  abort_cmd;
    logic [31:0] start_length_ms;
    logic        start_request;
    logic [2:0]  phase_now;
    logic [1:0]  event_code;
    logic        accepted;
  } status_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  // func
  logic [2:0]   in_tuser;
  // now_ms, order_tag, order_len_ms, then the eight status flags
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // accepted, event_code, phase_now, start_request, start_length_ms,
  // abort_cmd, standby_enable, dispensed_total_ms, continue_visible
  logic [79:0]  out_tdata;

  dispense_session_controller u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Model copy of configuration and session state
  logic [15:0] m_poll_iv;
  logic [3:0]  m_debounce;
  logic [31:0] m_pause_to, m_finish_hold, m_postpay_to;
  logic [2:0]  m_phase;
  logic [31:0] m_finish_dl, m_last_poll, m_contract, m_acc, m_seg, m_pause_dl;
  logic [31:0] m_pending, m_postpay_dl, m_last_order;
  logic [3:0]  m_streak;
  logic        m_poll_valid, m_pause_armed, m_resume_pending;
  // per-item command outputs
  logic        c_start;
  logic [31:0] c_len;
  logic [1:0]  c_abort;
  logic        c_stby;

  status_t     expected_status_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  longint unsigned cycle_count;
  bit          idle_enable;
  bit          rx_hold;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: far above the slowest correct run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("** dispense_session_controller: FAILED **");
        $finish;
      end
    end
  end

  function automatic bit deadline_hit(logic [31:0] t, logic [31:0] dl);
    logic [31:0] d;
    d = t - dl;
    return !d[31];
  endfunction

  function automatic logic [31:0] total_ms(logic [31:0] t);
    return (m_phase == PH_RUN) ? m_acc + (t - m_seg) : m_acc;
  endfunction

  function automatic logic [31:0] remaining_ms(logic [31:0] t);
    logic [31:0] u;
    if (m_contract == 0) return 0;
    u = total_ms(t);
    return (u >= m_contract) ? 32'd0 : m_contract - u;
  endfunction

  task automatic fold_running(logic [31:0] t);
    if (m_phase == PH_RUN) begin
      m_acc = m_acc + (t - m_seg);
      m_seg = 0;
    end
  endtask

  task automatic clear_presence();
    m_streak = 0;
    m_poll_valid = 0;
  endtask

  task automatic poll_presence(input logic [31:0] t, input bit sensed, input bit wanted,
                               output bit changed);
    logic [31:0] d;
    d = t - m_last_poll;
    changed = 0;
    if (m_poll_valid && (d[31] || d < {16'd0, m_poll_iv})) return;
    m_last_poll = t;
    m_poll_valid = 1;
    if (sensed == wanted) begin
      if (m_streak < m_debounce) m_streak++;
    end else begin
      m_streak = 0;
    end
    changed = (m_streak >= m_debounce);
  endtask

  task automatic enter_finished(logic [31:0] t);
    if (m_phase != PH_RUN && m_phase != PH_PAUSE) return;
    if (m_phase == PH_RUN) begin
      fold_running(t);
      c_abort = AB_ABORT;
    end
    m_pause_dl = 0;
    m_pause_armed = 0;
    m_resume_pending = 0;
    m_phase = PH_DONE;
    m_finish_dl = t + m_finish_hold;
    m_contract = 0;
  endtask

  task automatic enter_idle();
    m_phase = PH_IDLE;
    m_finish_dl = 0;
    m_last_poll = 0;
    m_poll_valid = 0;
    m_contract = 0;
    m_acc = 0;
    m_seg = 0;
    m_pause_dl = 0;
    m_pause_armed = 0;
    m_pending = 0;
    m_postpay_dl = 0;
    m_streak = 0;
    m_resume_pending = 0;
  endtask

  task automatic attempt_resume(input logic [31:0] t, input bit busy, input bit wake,
                                input bit ok, output bit took);
    logic [31:0] rest;
    rest = remaining_ms(t);
    took = 0;
    if (rest == 0) begin
      enter_finished(t);
      return;
    end
    if (!busy && wake) c_stby = 1;
    c_start = 1;
    c_len = rest;
    if (!ok) return;
    m_seg = t;
    m_resume_pending = 0;
    m_phase = PH_RUN;
    clear_presence();
    took = 1;
  endtask

  task automatic model_reset();
    m_poll_iv = 16'd100;
    m_debounce = 4'd3;
    m_pause_to = 60000;
    m_finish_hold = 3000;
    m_postpay_to = 120000;
    enter_idle();
    m_last_order = 0;
  endtask

  // Work out the result of one event item against the session model
  task automatic predict_event(input event_t e, output status_t r);
    bit acc, chg, took;
    logic [1:0] ev;
    logic [31:0] t;
    acc = 0; ev = EV_NONE; t = e.now_ms;
    c_start = 0; c_len = 0; c_abort = AB_NONE; c_stby = 0;
    case (e.func)
      FN_TICK: begin
        if (m_phase == PH_WAIT || m_phase == PH_READY) begin
          if (deadline_hit(t, m_postpay_dl)) begin
            enter_idle();
            ev = EV_POSTPAY;
          end else if (m_phase == PH_WAIT) begin
            poll_presence(t, e.container_present, 1'b1, chg);
            if (chg) begin m_phase = PH_READY; clear_presence(); end
          end else begin
            poll_presence(t, e.container_present, 1'b0, chg);
            if (chg) begin m_phase = PH_WAIT; clear_presence(); end
          end
        end else if (m_phase == PH_RUN) begin
          poll_presence(t, e.container_present, 1'b0, chg);
          if (chg) enter_finished(t);
          else begin
            if (!e.pump_busy && e.wake_ready) c_stby = 1;
            if (remaining_ms(t) == 0) begin
              fold_running(t);
              m_phase = PH_DONE;
              m_finish_dl = t + m_finish_hold;
              m_contract = 0;
            end
          end
        end else if (m_phase == PH_PAUSE) begin
          if (m_pause_armed && deadline_hit(t, m_pause_dl)) enter_finished(t);
          else begin
            poll_presence(t, e.container_present, 1'b0, chg);
            if (chg) enter_finished(t);
            else begin
              if (!e.pump_busy && e.wake_ready) c_stby = 1;
              if (m_resume_pending && !e.pump_busy && e.standby_on && e.container_present
                  && remaining_ms(t) > 0)
                attempt_resume(t, e.pump_busy, e.wake_ready, e.start_ok, took);
            end
          end
        end else if (m_phase == PH_DONE) begin
          if (deadline_hit(t, m_finish_dl)) m_phase = PH_WAITIDLE;
        end else if (m_phase == PH_WAITIDLE) begin
          if (e.done_seen || !e.pump_busy) begin
            enter_idle();
            c_stby = 1;
            ev = EV_IDLE;
          end
        end
      end
      FN_ORDER: begin
        if (e.order_tag != 0 && m_phase == PH_IDLE && e.order_tag != m_last_order
            && e.wake_ready) begin
          if (!e.standby_on) c_stby = 1;
          m_last_order = e.order_tag;
          m_pending = e.order_len_ms;
          m_contract = 0;
          m_acc = 0;
          m_seg = 0;
          m_postpay_dl = t + m_postpay_to;
          m_phase = e.container_present ? PH_READY : PH_WAIT;
          clear_presence();
          acc = 1;
        end
      end
      FN_START: begin
        if (m_phase == PH_READY && !e.tray_full && !e.tank_empty) begin
          if (!e.container_present) begin
            m_phase = PH_WAIT;
            clear_presence();
          end else begin
            c_start = 1;
            c_len = m_pending;
            if (e.start_ok) begin
              m_contract = m_pending;
              m_acc = 0;
              m_seg = t;
              m_pause_dl = 0;
              m_pause_armed = 0;
              m_postpay_dl = 0;
              m_resume_pending = 0;
              m_phase = PH_RUN;
              m_finish_dl = 0;
              clear_presence();
              acc = 1;
            end
          end
        end
      end
      FN_STOP: begin
        if (m_phase == PH_RUN) begin
          fold_running(t);
          c_abort = AB_PAUSE;
          m_phase = PH_PAUSE;
          m_pause_dl = t + m_pause_to;
          m_pause_armed = 1;
          m_resume_pending = 0;
          clear_presence();
          acc = 1;
        end
      end
      FN_CONTINUE: begin
        if (m_phase == PH_PAUSE && !e.tray_full && !e.tank_empty && e.container_present) begin
          if (remaining_ms(t) == 0) begin
            enter_finished(t);
            acc = 1;
          end else begin
            m_pause_dl = 0;
            m_pause_armed = 0;
            if (e.pump_busy) begin
              m_resume_pending = 1;
              acc = 1;
            end else begin
              attempt_resume(t, e.pump_busy, e.wake_ready, e.start_ok, took);
              acc = took;
            end
          end
        end
      end
      FN_FINISH: begin
        if (m_phase == PH_PAUSE) begin
          enter_finished(t);
          acc = 1;
        end
      end
      FN_FAULT: begin
        if (m_phase == PH_RUN) begin
          fold_running(t);
          c_abort = AB_ABORT;
        end
        enter_idle();
        acc = 1;
      end
      default: begin
        m_last_order = 0;
        acc = 1;
      end
    endcase
    r.accepted = acc;
    r.event_code = ev;
    r.phase_now = m_phase;
    r.start_request = c_start;
    r.start_length_ms = c_len;
    r.abort_cmd = c_abort;
    r.standby_enable = c_stby;
    r.dispensed_total_ms = total_ms(t);
    r.continue_visible = (m_phase == PH_PAUSE) && !m_resume_pending && !e.pump_busy
                         && e.standby_on && e.container_present && (remaining_ms(t) > 0);
  endtask

  // Send one event item; predict at the handshake edge so order is kept.
  // Valid stays high after the handshake: the next call replaces the item or drops it for a gap, or drain() drops it.
  task automatic send_event(event_t e);
    status_t r;
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= e.func;
    in_tdata  <= e[106:3];
    do @(posedge clk); while (!in_tready);
    predict_event(e, r);
    expected_status_q.push_back(r);
    items_sent++;
  endtask

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    status_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = status_t'(out_tdata[74:0]);
      results_seen++;
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_status_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at item %0d: expected %h got %h", results_seen, want, got);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    out_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
        out_tready <= 1'b1;
        rx_hold = 0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POLL:     m_poll_iv = val[15:0];
      CFG_DEBOUNCE: m_debounce = val[3:0];
      CFG_PAUSE:    m_pause_to = val;
      CFG_FINISH:   m_finish_hold = val;
      CFG_POSTPAY:  m_postpay_to = val;
      default: ;
    endcase
  endtask

  function automatic event_t make_event(logic [2:0] fn, logic [7:0] flags);
    event_t e;
    e.func = fn;
    clock_ms = clock_ms + $urandom_range(0, 300);
    e.now_ms = clock_ms;
    e.order_tag = $urandom_range(1, 6);
    e.order_len_ms = $urandom_range(50, 2000);
    {e.done_seen, e.start_ok, e.tank_empty, e.tray_full, e.standby_on, e.wake_ready,
     e.pump_busy, e.container_present} = flags;
    return e;
  endfunction

  // Flags that let a session move: present, ready to wake, standby, start ok; now and then random flags instead
  function automatic logic [7:0] good_flags();
    logic [7:0] f;
    f = 8'b0100_1101;
    if ($urandom_range(0, 7) == 0) f = 8'($urandom);
    return f;
  endfunction

  // Field extremes and every function at least once, in and out of the right phase
  task automatic test_directed();
    event_t e;
    e = make_event(FN_TICK, 8'hFF);
    e.now_ms = 32'hFFFF_FFFF; e.order_tag = 32'hFFFF_FFFF; e.order_len_ms = 32'hFFFF_FFFF;
    send_event(e);
    e = make_event(FN_ORDER, 8'h00); e.order_tag = 0; send_event(e);      // missing tag
    e = make_event(FN_ORDER, 8'b0000_0101); e.order_tag = 32'hFFFF_FFFF;
    e.order_len_ms = 32'hFFFF_FFFF; e.now_ms = 32'hFFFF_FF00; send_event(e);
    e = make_event(FN_ORDER, 8'b0000_0101); send_event(e);                // wrong phase
    e = make_event(FN_START, 8'b0101_0101); e.now_ms = 32'hFFFF_FF10; send_event(e);
    e = make_event(FN_TICK, 8'b0000_0100); e.now_ms = 32'h0000_0100; send_event(e); // wrap
    e = make_event(FN_STOP, 8'h0D); e.now_ms = 32'h0000_0200; send_event(e);
    e = make_event(FN_CONTINUE, 8'b0000_1101); e.now_ms = 32'h300; send_event(e);
    e = make_event(FN_STOP, 8'h0D); e.now_ms = 32'h380; send_event(e);
    e = make_event(FN_CONTINUE, 8'b0000_1111); e.now_ms = 32'h400; send_event(e); // busy
    e = make_event(FN_TICK, 8'b0100_1101); e.now_ms = 32'h500; send_event(e);
    e = make_event(FN_FINISH, 8'h0); send_event(e);
    e = make_event(FN_FAULT, 8'h0); send_event(e);
    e = make_event(FN_SRESET, 8'h0); send_event(e);
    e = make_event(FN_ORDER, 8'b0000_0101); e.order_tag = 32'hFFFF_FFFF; send_event(e);
    e = make_event(FN_START, 8'b0011_0101); send_event(e);                // tray and tank
    e = make_event(FN_START, 8'b1101_0101); send_event(e);
    e = make_event(FN_FAULT, 8'h0); send_event(e);
    drain();
  endtask

  // Well-formed sessions with random content, sprinkled with noise
  task automatic test_sessions(int n);
    event_t e;
    logic [2:0] fn;
    int k;
    for (k = 0; k < n; k++) begin
      case (m_phase)
        PH_IDLE:  fn = ($urandom_range(0, 9) == 0) ? FN_SRESET : FN_ORDER;
        PH_WAIT:  fn = FN_TICK;
        PH_READY: fn = ($urandom_range(0, 2) == 0) ? FN_TICK : FN_START;
        PH_RUN:   fn = ($urandom_range(0, 2) == 0) ? FN_STOP : FN_TICK;
        PH_PAUSE: fn = ($urandom_range(0, 3) == 0) ? FN_FINISH : FN_CONTINUE;
        default:  fn = FN_TICK;
      endcase
      if ($urandom_range(0, 9) == 0) fn = 3'($urandom_range(0, 7));
      e = make_event(fn, good_flags());
      if ($urandom_range(0, 30) == 0) e.now_ms = $urandom;
      if ($urandom_range(0, 30) == 0) e.order_len_ms = $urandom;
      if ($urandom_range(0, 30) == 0) e.order_tag = $urandom;
      if (fn == FN_TICK && $urandom_range(0, 2) == 0) e.container_present = 1'($urandom);
      send_event(e);
    end
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_POLL, 0);
    write_reg(CFG_DEBOUNCE, 0);
    write_reg(CFG_PAUSE, 0);
    write_reg(CFG_FINISH, 0);
    write_reg(CFG_POSTPAY, 32'hFFFF_FFFF);
    test_sessions(70);
    drain();
    write_reg(CFG_POLL, 32'h0000_FFFF);
    write_reg(CFG_DEBOUNCE, 15);
    write_reg(CFG_PAUSE, 32'hFFFF_FFFF);
    write_reg(CFG_FINISH, 32'hFFFF_FFFF);
    write_reg(CFG_POSTPAY, 0);
    test_sessions(50);
    drain();
    write_reg(CFG_POLL, 20);
    write_reg(CFG_DEBOUNCE, 1);
    write_reg(CFG_PAUSE, 500);
    write_reg(CFG_FINISH, 200);
    write_reg(CFG_POSTPAY, 5000);
    test_sessions(80);
    drain();
  endtask

  // Hold the receiver off for a long stretch while items keep coming
  task automatic test_backpressure();
    rx_hold = 1;
    test_sessions(40);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_tvalid = 1'b0; in_tuser = '0; in_tdata = '0;
    mismatches = 0; results_seen = 0; items_sent = 0;
    idle_enable = 1; rx_hold = 0; clock_ms = 0;
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_sessions(80);
    drain();
    test_config_extremes();
    test_backpressure();
    idle_enable = 0;   // last stretch runs flat out
    test_sessions(60);
    drain();
    $display("Covered %0d event items over directed, session, register and stall phases;",
             items_sent);
    $display("%0d results compared, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0 && expected_status_q.size() == 0) begin
      $display("** dispense_session_controller: PASSED **");
    end else begin
      $display("** dispense_session_controller: FAILED **");
    end
    $finish;
  end
endmodule
